>>> rtl/rbe_pkg.sv
// Shared types, constants and the control program of the RTT and bandwidth estimator.
// Used by rtl/rtt_bandwidth_estimator.sv and rtl/rbe_checker.sv; depends on nothing.

package rbe_pkg;

    // Default depth of the RTT sample ring.
    localparam int WINDOW_DEPTH_DEF = 16;

    // Channel widths.
    localparam int S_TDATA_W   = 160;
    localparam int S_TUSER_W   = 3;
    localparam int M_TDATA_W   = 264;
    localparam int M_TUSER_W   = 1;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_LENGTH = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_BURST     = 8'd1;

    // Register reset values.
    localparam logic [4:0]  WINDOW_LENGTH_RST = 5'd8;
    localparam logic [31:0] MIN_BURST_RST     = 32'd65536;

    localparam logic [31:0] MAX32     = 32'hFFFF_FFFF;
    localparam logic [41:0] MS_TO_US  = 42'd1000;
    localparam int          DIVIDEND_W = 35;
    localparam logic [5:0]  DIV_STEPS = 6'd35;

    // Sample kinds carried in s_tuser.
    typedef enum logic [1:0] {
        OP_RTT  = 2'd0,
        OP_BW   = 2'd1,
        OP_SYNC = 2'd2,
        OP_NONE = 2'd3
    } op_code_t;

    // Datapath operations selected by one control word.
    typedef enum logic [4:0] {
        UOP_WAIT,
        UOP_NOP,
        UOP_SAMPLE_SEL,
        UOP_RTT_DEV,
        UOP_JIT_A,
        UOP_JIT_B,
        UOP_AVG_A,
        UOP_RTT_COMMIT,
        UOP_BW_SYNC,
        UOP_DROP_TEST,
        UOP_DIV_INIT,
        UOP_DIV_STEP,
        UOP_DIV_DONE,
        UOP_BW_A,
        UOP_BW_COMMIT,
        UOP_SCAN_START,
        UOP_SCAN_READ,
        UOP_SCAN_STEP,
        UOP_EMIT
    } uop_t;

    // Jump conditions.
    typedef enum logic [3:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_REQ,
        COND_OP_BW,
        COND_OP_NONE,
        COND_OP_RTT,
        COND_DROP,
        COND_DIV_MORE,
        COND_SPAN_ZERO,
        COND_SCAN_MORE
    } cond_t;

    localparam int PC_W = 5;

    typedef struct packed {
        uop_t             uop;
        cond_t            cond;
        logic [PC_W-1:0]  target;
    } ctrl_t;

    // Program labels.
    localparam logic [PC_W-1:0] PC_WAIT       = 5'd0;
    localparam logic [PC_W-1:0] PC_BW_CHECK   = 5'd11;
    localparam logic [PC_W-1:0] PC_DIV_STEP   = 5'd13;
    localparam logic [PC_W-1:0] PC_BW_A       = 5'd15;
    localparam logic [PC_W-1:0] PC_SCAN_START = 5'd17;
    localparam logic [PC_W-1:0] PC_SCAN_STEP  = 5'd19;
    localparam logic [PC_W-1:0] PC_EMIT       = 5'd20;

    // The control program. A taken condition loads the target, otherwise the
    // step counter advances by one.
    function automatic ctrl_t micro_rom(input logic [PC_W-1:0] pc);
        ctrl_t cw;
        cw = '{UOP_WAIT, COND_ALWAYS, PC_WAIT};
        unique case (pc)
            5'd0:  cw = '{UOP_WAIT,       COND_NO_REQ,    PC_WAIT};
            5'd1:  cw = '{UOP_NOP,        COND_OP_BW,     PC_BW_CHECK};
            5'd2:  cw = '{UOP_NOP,        COND_OP_NONE,   PC_SCAN_START};
            5'd3:  cw = '{UOP_SAMPLE_SEL, COND_NEVER,     PC_WAIT};
            5'd4:  cw = '{UOP_RTT_DEV,    COND_NEVER,     PC_WAIT};
            5'd5:  cw = '{UOP_JIT_A,      COND_NEVER,     PC_WAIT};
            5'd6:  cw = '{UOP_JIT_B,      COND_NEVER,     PC_WAIT};
            5'd7:  cw = '{UOP_AVG_A,      COND_NEVER,     PC_WAIT};
            5'd8:  cw = '{UOP_RTT_COMMIT, COND_NEVER,     PC_WAIT};
            5'd9:  cw = '{UOP_NOP,        COND_OP_RTT,    PC_SCAN_START};
            5'd10: cw = '{UOP_BW_SYNC,    COND_ALWAYS,    PC_BW_A};
            5'd11: cw = '{UOP_DROP_TEST,  COND_DROP,      PC_SCAN_START};
            5'd12: cw = '{UOP_DIV_INIT,   COND_NEVER,     PC_WAIT};
            5'd13: cw = '{UOP_DIV_STEP,   COND_DIV_MORE,  PC_DIV_STEP};
            5'd14: cw = '{UOP_DIV_DONE,   COND_NEVER,     PC_WAIT};
            5'd15: cw = '{UOP_BW_A,       COND_NEVER,     PC_WAIT};
            5'd16: cw = '{UOP_BW_COMMIT,  COND_NEVER,     PC_WAIT};
            5'd17: cw = '{UOP_SCAN_START, COND_SPAN_ZERO, PC_EMIT};
            5'd18: cw = '{UOP_SCAN_READ,  COND_NEVER,     PC_WAIT};
            5'd19: cw = '{UOP_SCAN_STEP,  COND_SCAN_MORE, PC_SCAN_STEP};
            5'd20: cw = '{UOP_EMIT,       COND_ALWAYS,    PC_WAIT};
            default: cw = '{UOP_WAIT, COND_ALWAYS, PC_WAIT};
        endcase
        return cw;
    endfunction

endpackage

>>> rtl/rtt_bandwidth_estimator.sv
// Top level of the RTT and bandwidth link-quality estimator, a microcoded sequencer.
// Depends on rtl/rbe_pkg.sv for types, constants and the control program.
//
//  Channel   Dir  Handshake          Payload
//  s_        in   s_tvalid/s_tready  s_tdata: rtt_sample_us, burst_bytes, burst_ms,
//                                    sync_rtt_ms, sync_kbps;
//                                    s_tuser: op, connect_flag
//  m_        out  m_tvalid/m_tready  m_tdata: full estimate; m_tuser: accepted
//  cfg_      in   cfg_valid/cfg_ready cfg_index, cfg_data (window_length, burst_floor)
//
// RTT samples update the RTT estimate; sync items update both estimates; bandwidth results
// run a 35-step restoring divider; dropped results and unused ops skip the updates. Every
// request then scans n window entries (one ring read per cycle); with n = 0 the read step is
// skipped. Reset is synchronous, active low, no ring clear.
// The next request is taken once the previous result is in the output register; a stalled
// output holds the sequencer in its final step.

module rtt_bandwidth_estimator #(
    parameter int WINDOW_DEPTH = rbe_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input requests.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // From bit 0: rtt_sample_us[31:0], burst_bytes[63:32], burst_ms[95:64],
    // sync_rtt_ms[127:96], sync_kbps[159:128].
    input  logic [rbe_pkg::S_TDATA_W-1:0]     s_tdata,
    // From bit 0: op[1:0], connect_flag[2].
    input  logic [rbe_pkg::S_TUSER_W-1:0]     s_tuser,
    // Results.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // From bit 0: avg_rtt_us[31:0], jitter_us[63:32], window_min_us[95:64],
    // newest_rtt_us[127:96], rtt_valid[128], rtt_sample_count[160:129],
    // bw_estimate_kbps[192:161], newest_bw_kbps[224:193], bandwidth_valid[225],
    // bandwidth_sample_count[257:226], zero fill[263:258].
    output logic [rbe_pkg::M_TDATA_W-1:0]     m_tdata,
    // From bit 0: accepted[0].
    output logic [rbe_pkg::M_TUSER_W-1:0]     m_tuser,
    // Configuration writes.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rbe_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [rbe_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // Ring address, fill count and span compare widths.
    localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int FW = $clog2(WINDOW_DEPTH + 1);
    localparam int CW = (FW > 5) ? FW : 5;
    localparam logic [AW-1:0] RING_LAST = AW'(WINDOW_DEPTH - 1);
    localparam logic [FW-1:0] RING_FULL = FW'(WINDOW_DEPTH);
    localparam int DW = rbe_pkg::DIVIDEND_W;

    // Sequencer.
    logic [rbe_pkg::PC_W-1:0] pc_reg, pc_next;
    rbe_pkg::ctrl_t           cw;
    logic                     take_jump;
    logic                     emit_stall;
    logic                     s_fire;

    // Configuration.
    logic [4:0]  wl_reg;
    logic [31:0] mbb_reg;

    // Captured request.
    rbe_pkg::op_code_t op_reg;
    logic              ct_reg;
    logic [31:0]       rtt_us_reg;
    logic [31:0]       bytes_reg;
    logic [31:0]       delta_reg;
    logic [31:0]       sync_ms_reg;
    logic [31:0]       sync_kbps_reg;
    logic              accepted_reg;

    // Estimator state.
    logic [31:0]   rtt_avg_reg;
    logic [31:0]   rtt_jit_reg;
    logic          rtt_seen_reg;
    logic [31:0]   rtt_latest_reg;
    logic [31:0]   rtt_count_reg;
    logic [AW-1:0] head_reg;
    logic [FW-1:0] fill_reg;
    logic [31:0]   bw_est_reg;
    logic          bw_seen_reg;
    logic [31:0]   bw_latest_reg;
    logic [31:0]   bw_count_reg;

    // Datapath scratch registers.
    logic [31:0]   dev_reg;
    logic [DW-1:0] acc_reg;
    logic [31:0]   kb_reg;
    logic [31:0]   rem_reg;
    logic [DW-1:0] quo_reg;
    logic [31:0]   divisor_reg;
    logic [5:0]    div_cnt_reg;
    logic [AW-1:0] ptr_reg;
    logic [FW-1:0] scan_cnt_reg;
    logic [31:0]   best_reg;
    logic          first_reg;
    logic [31:0]   rd_data_reg;

    // Output register.
    logic                          m_tvalid_reg;
    logic [rbe_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic [rbe_pkg::M_TUSER_W-1:0] m_tuser_reg;

    // Sample ring; entries are only read after they have been written.
    logic [31:0] ring_mem [WINDOW_DEPTH];

    // Combinational helpers.
    logic [41:0]   sync_prod;
    logic          drop;
    logic [32:0]   rem_shift;
    logic          div_ge;
    logic [32:0]   rem_diff;
    logic [CW-1:0] span_wide;
    logic [FW-1:0] span;
    logic [AW-1:0] head_prev;
    logic [AW-1:0] ptr_prev;
    logic [DW-1:0] jit_sum;
    logic [DW-1:0] avg_sum;
    logic [32:0]   bw_half_sum;
    logic [DW-1:0] bw_qtr_sum;

    assign cw         = rbe_pkg::micro_rom(pc_reg);
    assign s_tready   = aresetn && (cw.uop == rbe_pkg::UOP_WAIT);
    assign s_fire     = s_tvalid && s_tready;
    assign cfg_ready  = aresetn;
    assign emit_stall = (cw.uop == rbe_pkg::UOP_EMIT) && m_tvalid_reg && !m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Sync RTT arrives in milliseconds and saturates after scaling to microseconds.
    assign sync_prod = {10'd0, sync_ms_reg} * rbe_pkg::MS_TO_US;

    // Continuous results below half the burst size are ignored.
    assign drop = !ct_reg && (bytes_reg < (mbb_reg >> 1));

    // One restoring division step: shift in the next dividend bit and try to subtract.
    assign rem_shift = {rem_reg, quo_reg[DW-1]};
    assign div_ge    = rem_shift >= {1'b0, divisor_reg};
    assign rem_diff  = rem_shift - {1'b0, divisor_reg};

    // The span is the configured window length, forced into 1..WINDOW_DEPTH, and
    // limited to the number of samples taken so far.
    always_comb begin
        span_wide = (wl_reg == 5'd0) ? CW'(1) : CW'(wl_reg);
        if (span_wide > CW'(WINDOW_DEPTH)) begin
            span_wide = CW'(WINDOW_DEPTH);
        end
        if (span_wide > CW'(fill_reg)) begin
            span_wide = CW'(fill_reg);
        end
        span = span_wide[FW-1:0];
    end

    // The ring walks backward from the newest sample.
    assign head_prev = (head_reg == '0) ? RING_LAST : head_reg - AW'(1);
    assign ptr_prev  = (ptr_reg == '0) ? RING_LAST : ptr_reg - AW'(1);

    // Weighted sums; acc_reg holds the 3x or 7x term computed in the step before.
    assign jit_sum     = acc_reg + DW'(dev_reg);
    assign avg_sum     = acc_reg + DW'(rtt_us_reg);
    assign bw_half_sum = {1'b0, bw_est_reg} + {1'b0, kb_reg};
    assign bw_qtr_sum  = acc_reg + DW'(kb_reg);

    // Jump decision.
    always_comb begin
        unique case (cw.cond)
            rbe_pkg::COND_NEVER:     take_jump = 1'b0;
            rbe_pkg::COND_ALWAYS:    take_jump = 1'b1;
            rbe_pkg::COND_NO_REQ:    take_jump = !s_fire;
            rbe_pkg::COND_OP_BW:     take_jump = (op_reg == rbe_pkg::OP_BW);
            rbe_pkg::COND_OP_NONE:   take_jump = (op_reg == rbe_pkg::OP_NONE);
            rbe_pkg::COND_OP_RTT:    take_jump = (op_reg == rbe_pkg::OP_RTT);
            rbe_pkg::COND_DROP:      take_jump = drop;
            rbe_pkg::COND_DIV_MORE:  take_jump = (div_cnt_reg != 6'd1);
            rbe_pkg::COND_SPAN_ZERO: take_jump = (span == '0);
            rbe_pkg::COND_SCAN_MORE: take_jump = (scan_cnt_reg != FW'(1));
            default:                 take_jump = 1'b0;
        endcase
        if (emit_stall) begin
            pc_next = pc_reg;
        end else if (take_jump) begin
            pc_next = cw.target;
        end else begin
            pc_next = pc_reg + rbe_pkg::PC_W'(1);
        end
    end

    // Ring write on an RTT commit, registered read while scanning.
    always_ff @(posedge aclk) begin
        if (cw.uop == rbe_pkg::UOP_RTT_COMMIT) begin
            ring_mem[head_reg] <= rtt_us_reg;
        end
        if ((cw.uop == rbe_pkg::UOP_SCAN_READ) || (cw.uop == rbe_pkg::UOP_SCAN_STEP)) begin
            rd_data_reg <= ring_mem[ptr_reg];
        end
    end

    // Sequencer, configuration and datapath.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg         <= rbe_pkg::PC_WAIT;
            wl_reg         <= rbe_pkg::WINDOW_LENGTH_RST;
            mbb_reg        <= rbe_pkg::MIN_BURST_RST;
            rtt_avg_reg    <= '0;
            rtt_jit_reg    <= '0;
            rtt_seen_reg   <= 1'b0;
            rtt_latest_reg <= '0;
            rtt_count_reg  <= '0;
            head_reg       <= '0;
            fill_reg       <= '0;
            bw_est_reg     <= '0;
            bw_seen_reg    <= 1'b0;
            bw_latest_reg  <= '0;
            bw_count_reg   <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            pc_reg <= pc_next;

            if (cfg_valid && cfg_ready) begin
                if (cfg_index == rbe_pkg::CFG_WINDOW_LENGTH) begin
                    wl_reg <= cfg_data[4:0];
                end else if (cfg_index == rbe_pkg::CFG_MIN_BURST) begin
                    mbb_reg <= cfg_data;
                end
            end

            // A result is loaded when the final step runs unstalled; a taken result clears.
            if ((cw.uop == rbe_pkg::UOP_EMIT) && !emit_stall) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            case (cw.uop)
                rbe_pkg::UOP_WAIT: begin
                    if (s_fire) begin
                        op_reg        <= rbe_pkg::op_code_t'(s_tuser[1:0]);
                        ct_reg        <= s_tuser[2];
                        rtt_us_reg    <= s_tdata[31:0];
                        bytes_reg     <= s_tdata[63:32];
                        delta_reg     <= s_tdata[95:64];
                        sync_ms_reg   <= s_tdata[127:96];
                        sync_kbps_reg <= s_tdata[159:128];
                        accepted_reg  <= (s_tuser[1:0] != rbe_pkg::OP_NONE);
                    end
                end
                rbe_pkg::UOP_SAMPLE_SEL: begin
                    if (op_reg == rbe_pkg::OP_SYNC) begin
                        rtt_us_reg <= (sync_prod[41:32] != 10'd0) ? rbe_pkg::MAX32
                                                                 : sync_prod[31:0];
                    end
                end
                rbe_pkg::UOP_RTT_DEV: begin
                    dev_reg <= (rtt_us_reg > rtt_avg_reg) ? rtt_us_reg - rtt_avg_reg
                                                          : rtt_avg_reg - rtt_us_reg;
                end
                rbe_pkg::UOP_JIT_A: begin
                    acc_reg <= DW'(rtt_jit_reg) + DW'({rtt_jit_reg, 1'b0});
                end
                rbe_pkg::UOP_JIT_B: begin
                    // The first sample seeds the jitter with half of itself.
                    rtt_jit_reg <= rtt_seen_reg ? jit_sum[33:2] : {1'b0, rtt_us_reg[31:1]};
                end
                rbe_pkg::UOP_AVG_A: begin
                    acc_reg <= {rtt_avg_reg, 3'b000} - DW'(rtt_avg_reg);
                end
                rbe_pkg::UOP_RTT_COMMIT: begin
                    rtt_avg_reg    <= rtt_seen_reg ? avg_sum[DW-1:3] : rtt_us_reg;
                    rtt_seen_reg   <= 1'b1;
                    rtt_latest_reg <= rtt_us_reg;
                    head_reg       <= (head_reg == RING_LAST) ? '0 : head_reg + AW'(1);
                    if (fill_reg != RING_FULL) begin
                        fill_reg <= fill_reg + FW'(1);
                    end
                    if (rtt_count_reg != rbe_pkg::MAX32) begin
                        rtt_count_reg <= rtt_count_reg + 32'd1;
                    end
                end
                rbe_pkg::UOP_BW_SYNC: begin
                    kb_reg <= sync_kbps_reg;
                end
                rbe_pkg::UOP_DROP_TEST: begin
                    if (drop) begin
                        accepted_reg <= 1'b0;
                    end
                end
                rbe_pkg::UOP_DIV_INIT: begin
                    rem_reg     <= '0;
                    quo_reg     <= {bytes_reg, 3'b000};
                    divisor_reg <= (delta_reg == 32'd0) ? 32'd1 : delta_reg;
                    div_cnt_reg <= rbe_pkg::DIV_STEPS;
                end
                rbe_pkg::UOP_DIV_STEP: begin
                    rem_reg     <= div_ge ? rem_diff[31:0] : rem_shift[31:0];
                    quo_reg     <= {quo_reg[DW-2:0], div_ge};
                    div_cnt_reg <= div_cnt_reg - 6'd1;
                end
                rbe_pkg::UOP_DIV_DONE: begin
                    kb_reg <= (quo_reg[DW-1:32] != '0) ? rbe_pkg::MAX32 : quo_reg[31:0];
                end
                rbe_pkg::UOP_BW_A: begin
                    acc_reg <= DW'(bw_est_reg) + DW'({bw_est_reg, 1'b0});
                end
                rbe_pkg::UOP_BW_COMMIT: begin
                    // Falls fast toward a lower sample, rises slowly toward a higher one.
                    bw_latest_reg <= kb_reg;
                    if (!bw_seen_reg) begin
                        bw_est_reg <= kb_reg;
                    end else if (kb_reg < bw_est_reg) begin
                        bw_est_reg <= bw_half_sum[32:1];
                    end else begin
                        bw_est_reg <= bw_qtr_sum[33:2];
                    end
                    bw_seen_reg <= 1'b1;
                    if (bw_count_reg != rbe_pkg::MAX32) begin
                        bw_count_reg <= bw_count_reg + 32'd1;
                    end
                end
                rbe_pkg::UOP_SCAN_START: begin
                    ptr_reg      <= head_prev;
                    scan_cnt_reg <= span;
                    best_reg     <= '0;
                    first_reg    <= 1'b1;
                end
                rbe_pkg::UOP_SCAN_READ: begin
                    ptr_reg <= ptr_prev;
                end
                rbe_pkg::UOP_SCAN_STEP: begin
                    if (first_reg || (rd_data_reg < best_reg)) begin
                        best_reg <= rd_data_reg;
                    end
                    first_reg    <= 1'b0;
                    ptr_reg      <= ptr_prev;
                    scan_cnt_reg <= scan_cnt_reg - FW'(1);
                end
                rbe_pkg::UOP_EMIT: begin
                    if (!emit_stall) begin
                        m_tdata_reg  <= {6'd0, bw_count_reg, bw_seen_reg, bw_latest_reg,
                                         bw_est_reg, rtt_count_reg, rtt_seen_reg,
                                         rtt_latest_reg, best_reg, rtt_jit_reg, rtt_avg_reg};
                        m_tuser_reg  <= accepted_reg;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

>>> rtl/rbe_checker.sv
// Port-level checks for the RTT and bandwidth estimator, bound to its top level.
// Depends on rtl/rbe_pkg.sv and rtl/rtt_bandwidth_estimator.sv.

module rbe_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [rbe_pkg::M_TDATA_W-1:0]     m_tdata,
    input logic [rbe_pkg::M_TUSER_W-1:0]     m_tuser
);

    // One request is worked on at a time.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken again right after a request");

    // A stalled result holds.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

    // Without any RTT sample the RTT estimate and its count stay zero.
    a_rtt_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[128]) |->
            (m_tdata[31:0] == 32'd0 && m_tdata[95:64] == 32'd0 && m_tdata[160:129] == 32'd0))
        else $error("RTT estimate nonzero before any sample");

    // Without any bandwidth sample the bandwidth estimate and its count stay zero.
    a_bw_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[225]) |->
            (m_tdata[192:161] == 32'd0 && m_tdata[257:226] == 32'd0))
        else $error("bandwidth estimate nonzero before any sample");

endmodule

bind rtt_bandwidth_estimator rbe_checker u_rbe_checker (.*);
